// ===== rtl/core/wsmc_pkg.sv =====
// Shared types and constants of the weld sequence mode controller.
// Used by the front, queue and back modules and by the top level.
`default_nettype none
package wsmc_pkg;

	// Default width of the stored tracking offsets
	localparam int OFFSET_BITS_DEF = 16;
	// Width used to sign-extend offsets between their stored and reported forms
	localparam int WIDE_BITS = 32;
	// Entries in the queue between the front and the back
	localparam int QUEUE_DEPTH = 2;

	// Input event codes
	localparam logic [3:0] CMD_CONTROLLER = 4'd0;
	localparam logic [3:0] CMD_TRACK_PARAMS = 4'd1;
	localparam logic [3:0] CMD_READY_REPORT = 4'd2;
	localparam logic [3:0] CMD_HANDOVER = 4'd3;
	localparam logic [3:0] CMD_GROOVE_TIMEOUT = 4'd4;
	localparam logic [3:0] CMD_SCANNER_ERROR = 4'd5;
	localparam logic [3:0] CMD_CAP_READY = 4'd6;
	localparam logic [3:0] CMD_HEARTBEAT_LOST = 4'd7;
	localparam logic [3:0] CMD_DISCONNECT = 4'd8;
	localparam logic [3:0] CMD_TICK = 4'd9;

	// Requested sequence kinds in a controller command
	localparam logic [1:0] REQ_NONE = 2'd0;
	localparam logic [1:0] REQ_TRACKING = 2'd1;
	localparam logic [1:0] REQ_AUTO_WELD = 2'd2;
	localparam logic [1:0] REQ_AUTO_CAP = 2'd3;

	// Ready levels reported by the service
	localparam logic [2:0] RDY_NOT_READY = 3'd0;
	localparam logic [2:0] RDY_CAL_MOVE = 3'd1;
	localparam logic [2:0] RDY_TRACKING = 3'd2;
	localparam logic [2:0] RDY_WELD = 3'd3;
	localparam logic [2:0] RDY_CAP = 3'd4;

	// Active sequence codes in the status report
	localparam logic [2:0] ACT_SEQ_NONE = 3'd0;
	localparam logic [2:0] ACT_SEQ_TRACKING = 3'd1;
	localparam logic [2:0] ACT_SEQ_AUTO_WELD = 3'd2;
	localparam logic [2:0] ACT_SEQ_CAL_MOVE = 3'd3;
	localparam logic [2:0] ACT_SEQ_CAP_WELD = 3'd4;

	// Outgoing message kinds
	typedef enum logic [3:0] {
		MSG_TRACK_START = 4'd0,
		MSG_TRACK_UPDATE = 4'd1,
		MSG_WELD_START = 4'd2,
		MSG_WELD_STOP = 4'd3,
		MSG_CAP_START = 4'd4,
		MSG_CAP_STOP = 4'd5,
		MSG_STOP = 4'd6,
		MSG_SHUTDOWN = 4'd7,
		MSG_STATUS = 4'd8
	} msg_kind_t;

	// One queued item: one or two messages with the values they report
	typedef struct packed {
		logic        two;
		msg_kind_t   kind_a;
		msg_kind_t   kind_b;
		logic [7:0]  mode;
		logic [15:0] horizontal;
		logic [15:0] vertical;
		logic [9:0]  flags;
		logic [2:0]  sequence_code;
	} plan_t;

	// Queue status seen by its producer and consumer
	typedef struct packed {
		logic full;
		logic not_empty;
	} queue_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/weld_sequence_mode_controller.sv =====
// Weld sequence mode controller, top level: front, plan queue and back.
// Depends on wsmc_pkg, wsmc_front, wsmc_queue and wsmc_back.
//
// Usage:
//   Event items enter on cmd_valid/cmd_ready with the event code and its
//   fields. Each item is decoded in the cycle it is accepted: the mode, ready
//   level, flags and tracking parameters update at that edge, and the
//   messages it causes (none, one or two, or one status report for a tick)
//   are written as one plan into a two-entry queue.
//   Messages leave on msg_valid/msg_ready from an output register, one per
//   cycle while msg_ready is high; last_of_run marks the final message of
//   an item. A message passes through the queue and then the output
//   register. The input takes one item per cycle while items cause at most
//   one message each and msg_ready is high; an item causing two messages
//   holds the back end for both, as they share the single output register.
//   cmd_ready is low only while the queue is full, so a stalled receiver
//   stops the input after the queue and output register have filled; no
//   item or message is lost.
//   Reset (arst_n low) returns the mode to idle, the ready level to not
//   ready, clears both flags and the tracking parameters, and empties the
//   queue and output register. Items are taken as soon as reset is released.
`default_nettype none
module weld_sequence_mode_controller #(
	parameter int OFFSET_BITS = wsmc_pkg::OFFSET_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_ready,
	input  wire logic [3:0]         command,
	input  wire logic               start_req,
	input  wire logic               stop_req,
	input  wire logic               shutdown_req,
	input  wire logic [1:0]         sequence_kind,
	input  wire logic [2:0]         ready_level,
	input  wire logic [7:0]         joint_mode,
	input  wire logic signed [15:0] offset_horizontal,
	input  wire logic signed [15:0] offset_vertical,
	output logic                    msg_valid,
	input  wire logic               msg_ready,
	output logic [3:0]              message_kind,
	output logic [7:0]              mode_out,
	output logic signed [15:0]      horizontal_out,
	output logic signed [15:0]      vertical_out,
	output logic [9:0]              status_flags,
	output logic [2:0]              active_sequence,
	output logic                    last_of_run
);

	logic                   push;
	logic                   pop;
	wsmc_pkg::plan_t        push_plan;
	wsmc_pkg::plan_t        head_plan;
	wsmc_pkg::queue_stat_t  q_stat;

	// Decode and state
	wsmc_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.command(command),
		.start_req(start_req),
		.stop_req(stop_req),
		.shutdown_req(shutdown_req),
		.sequence_kind(sequence_kind),
		.ready_level(ready_level),
		.joint_mode(joint_mode),
		.offset_horizontal(offset_horizontal),
		.offset_vertical(offset_vertical),
		.q_stat(q_stat),
		.push(push),
		.push_plan(push_plan)
	);

	// Plan queue
	wsmc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_plan(push_plan),
		.pop(pop),
		.head_plan(head_plan),
		.q_stat(q_stat)
	);

	// Message output
	wsmc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_plan(head_plan),
		.q_stat(q_stat),
		.pop(pop),
		.msg_valid(msg_valid),
		.msg_ready(msg_ready),
		.message_kind(message_kind),
		.mode_out(mode_out),
		.horizontal_out(horizontal_out),
		.vertical_out(vertical_out),
		.status_flags(status_flags),
		.active_sequence(active_sequence),
		.last_of_run(last_of_run)
	);

endmodule
`default_nettype wire

// ===== rtl/core/wsmc_front.sv =====
// Front part: accepts event items, keeps the interface mode, ready level,
// flags and tracking parameters, and writes the resulting message plan. Uses wsmc_pkg.
`default_nettype none
module wsmc_front #(
	parameter int OFFSET_BITS = wsmc_pkg::OFFSET_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_ready,
	input  wire logic [3:0]         command,
	input  wire logic               start_req,
	input  wire logic               stop_req,
	input  wire logic               shutdown_req,
	input  wire logic [1:0]         sequence_kind,
	input  wire logic [2:0]         ready_level,
	input  wire logic [7:0]         joint_mode,
	input  wire logic signed [15:0] offset_horizontal,
	input  wire logic signed [15:0] offset_vertical,
	input  wire wsmc_pkg::queue_stat_t q_stat,
	output logic                    push,
	output wsmc_pkg::plan_t         push_plan
);

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_TRACK = 3'd1,
		MODE_WELD = 3'd2,
		MODE_CAP = 3'd3,
		MODE_ERROR = 3'd4
	} if_mode_t;

	if_mode_t                       mode_q, mode_d;
	logic [2:0]                     level_q, level_d;
	logic                           handover_q, handover_d;
	logic                           cap_rdy_q, cap_rdy_d;
	logic [7:0]                     joint_q, joint_d;
	logic signed [OFFSET_BITS-1:0]  horizontal_q, horizontal_d;
	logic signed [OFFSET_BITS-1:0]  vertical_q, vertical_d;

	logic                           accept;
	logic                           has_msg;
	logic                           start_bad;
	logic signed [wsmc_pkg::WIDE_BITS-1:0] h_in_wide, v_in_wide, h_out_wide, v_out_wide;
	logic                           rdy, act, err, r_trk, r_weld, r_acap;
	logic [2:0]                     seq_code;

	assign cmd_ready = !q_stat.full;
	assign accept = cmd_valid && cmd_ready;
	assign push = accept && has_msg;

	// Offsets are wrapped to the stored width, reported as their low 16 bits
	assign h_in_wide = wsmc_pkg::WIDE_BITS'(offset_horizontal);
	assign v_in_wide = wsmc_pkg::WIDE_BITS'(offset_vertical);
	assign h_out_wide = wsmc_pkg::WIDE_BITS'(horizontal_d);
	assign v_out_wide = wsmc_pkg::WIDE_BITS'(vertical_d);

	// A start is refused when the ready level does not allow the sequence
	assign start_bad = (sequence_kind == wsmc_pkg::REQ_AUTO_WELD && level_q != wsmc_pkg::RDY_WELD)
		|| (sequence_kind == wsmc_pkg::REQ_AUTO_CAP && level_q != wsmc_pkg::RDY_CAP)
		|| (sequence_kind == wsmc_pkg::REQ_TRACKING && level_q == wsmc_pkg::RDY_NOT_READY);

	// Event decode: next state and message plan
	always_comb begin
		mode_d = mode_q;
		level_d = level_q;
		handover_d = handover_q;
		cap_rdy_d = cap_rdy_q;
		joint_d = joint_q;
		horizontal_d = horizontal_q;
		vertical_d = vertical_q;
		has_msg = 1'b0;
		push_plan.two = 1'b0;
		push_plan.kind_a = wsmc_pkg::MSG_STATUS;
		push_plan.kind_b = wsmc_pkg::MSG_STATUS;
		rdy = 1'b0;
		act = 1'b0;
		err = 1'b0;
		r_trk = 1'b0;
		r_weld = 1'b0;
		r_acap = 1'b0;
		seq_code = wsmc_pkg::ACT_SEQ_NONE;
		case (command)
			wsmc_pkg::CMD_CONTROLLER: begin
				if (shutdown_req) begin
					mode_d = MODE_IDLE;
					handover_d = 1'b0;
					has_msg = 1'b1;
					push_plan.kind_a = wsmc_pkg::MSG_SHUTDOWN;
				end else if (stop_req) begin
					if (mode_q == MODE_TRACK || mode_q == MODE_WELD || mode_q == MODE_CAP) begin
						has_msg = 1'b1;
						push_plan.kind_a = wsmc_pkg::MSG_STOP;
					end
					mode_d = MODE_IDLE;
					handover_d = 1'b0;
				end else if (start_req) begin
					if (start_bad) begin
						mode_d = MODE_ERROR;
					end else begin
						case (mode_q)
							MODE_IDLE: begin
								if (sequence_kind == wsmc_pkg::REQ_TRACKING) begin
									mode_d = MODE_TRACK;
									has_msg = 1'b1;
									push_plan.kind_a = wsmc_pkg::MSG_TRACK_START;
								end else if (sequence_kind == wsmc_pkg::REQ_AUTO_WELD) begin
									mode_d = MODE_WELD;
									has_msg = 1'b1;
									push_plan.two = 1'b1;
									push_plan.kind_a = wsmc_pkg::MSG_TRACK_START;
									push_plan.kind_b = wsmc_pkg::MSG_WELD_START;
								end else if (sequence_kind == wsmc_pkg::REQ_AUTO_CAP) begin
									mode_d = MODE_ERROR;
								end
							end
							MODE_TRACK: begin
								if (sequence_kind == wsmc_pkg::REQ_AUTO_WELD) begin
									mode_d = MODE_WELD;
									has_msg = 1'b1;
									push_plan.kind_a = wsmc_pkg::MSG_WELD_START;
								end else if (sequence_kind == wsmc_pkg::REQ_AUTO_CAP) begin
									mode_d = MODE_CAP;
									has_msg = 1'b1;
									push_plan.kind_a = wsmc_pkg::MSG_CAP_START;
								end
							end
							MODE_WELD: begin
								if (sequence_kind == wsmc_pkg::REQ_TRACKING) begin
									mode_d = MODE_TRACK;
									has_msg = 1'b1;
									push_plan.two = 1'b1;
									push_plan.kind_a = wsmc_pkg::MSG_WELD_STOP;
									push_plan.kind_b = wsmc_pkg::MSG_TRACK_UPDATE;
								end else if (sequence_kind == wsmc_pkg::REQ_AUTO_CAP) begin
									mode_d = MODE_CAP;
									has_msg = 1'b1;
									push_plan.two = 1'b1;
									push_plan.kind_a = wsmc_pkg::MSG_CAP_START;
									push_plan.kind_b = wsmc_pkg::MSG_TRACK_UPDATE;
								end
							end
							MODE_CAP: begin
								if (sequence_kind == wsmc_pkg::REQ_TRACKING) begin
									mode_d = MODE_TRACK;
									has_msg = 1'b1;
									push_plan.two = 1'b1;
									push_plan.kind_a = wsmc_pkg::MSG_CAP_STOP;
									push_plan.kind_b = wsmc_pkg::MSG_TRACK_UPDATE;
								end else if (sequence_kind == wsmc_pkg::REQ_AUTO_WELD) begin
									mode_d = MODE_ERROR;
								end
							end
							default: begin
								mode_d = MODE_ERROR;
							end
						endcase
					end
				end
			end
			wsmc_pkg::CMD_TRACK_PARAMS: begin
				joint_d = joint_mode;
				horizontal_d = h_in_wide[OFFSET_BITS-1:0];
				vertical_d = v_in_wide[OFFSET_BITS-1:0];
				if (mode_q == MODE_TRACK) begin
					has_msg = 1'b1;
					push_plan.kind_a = wsmc_pkg::MSG_TRACK_UPDATE;
				end
			end
			wsmc_pkg::CMD_READY_REPORT: begin
				if (ready_level <= wsmc_pkg::RDY_CAP) begin
					level_d = ready_level;
				end
			end
			wsmc_pkg::CMD_HANDOVER: begin
				handover_d = 1'b1;
			end
			wsmc_pkg::CMD_GROOVE_TIMEOUT, wsmc_pkg::CMD_SCANNER_ERROR: begin
				mode_d = MODE_ERROR;
			end
			wsmc_pkg::CMD_CAP_READY: begin
				cap_rdy_d = 1'b1;
			end
			wsmc_pkg::CMD_HEARTBEAT_LOST, wsmc_pkg::CMD_DISCONNECT: begin
				if (mode_q == MODE_TRACK || mode_q == MODE_WELD) begin
					has_msg = 1'b1;
					push_plan.kind_a = wsmc_pkg::MSG_STOP;
				end
				mode_d = MODE_ERROR;
			end
			wsmc_pkg::CMD_TICK: begin
				has_msg = 1'b1;
				case (mode_q)
					MODE_IDLE: begin
						rdy = 1'b1;
						cap_rdy_d = 1'b0;
					end
					MODE_TRACK: begin
						act = 1'b1;
						seq_code = wsmc_pkg::ACT_SEQ_TRACKING;
						cap_rdy_d = 1'b0;
					end
					MODE_WELD: begin
						act = 1'b1;
						seq_code = wsmc_pkg::ACT_SEQ_AUTO_WELD;
					end
					MODE_CAP: begin
						act = 1'b1;
						seq_code = wsmc_pkg::ACT_SEQ_CAP_WELD;
					end
					default: begin
						act = 1'b1;
						err = 1'b1;
						cap_rdy_d = 1'b0;
					end
				endcase
				case (level_q)
					wsmc_pkg::RDY_CAL_MOVE: begin
						rdy = 1'b0;
						act = 1'b1;
						seq_code = wsmc_pkg::ACT_SEQ_CAL_MOVE;
					end
					wsmc_pkg::RDY_TRACKING: begin
						r_trk = 1'b1;
					end
					wsmc_pkg::RDY_WELD: begin
						r_trk = 1'b1;
						r_weld = 1'b1;
					end
					wsmc_pkg::RDY_CAP: begin
						r_trk = 1'b1;
						r_weld = 1'b1;
						r_acap = 1'b1;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
		// Tracking values come from the state after this event
		push_plan.mode = joint_d;
		push_plan.horizontal = h_out_wide[15:0];
		push_plan.vertical = v_out_wide[15:0];
		// Status bits set only by the tick decode are zero for anything but a tick
		push_plan.flags = {handover_d, err, mode_q != MODE_IDLE, cap_rdy_d,
			r_acap, r_weld, r_trk, err, act, rdy};
		push_plan.sequence_code = seq_code;
	end

	// State update on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			level_q <= wsmc_pkg::RDY_NOT_READY;
			handover_q <= 1'b0;
			cap_rdy_q <= 1'b0;
			joint_q <= '0;
			horizontal_q <= '0;
			vertical_q <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			level_q <= level_d;
			handover_q <= handover_d;
			cap_rdy_q <= cap_rdy_d;
			joint_q <= joint_d;
			horizontal_q <= horizontal_d;
			vertical_q <= vertical_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/wsmc_queue.sv =====
// Short queue of message plans between the front and the back.
// Uses wsmc_pkg for the plan type and depth.
`default_nettype none
module wsmc_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire wsmc_pkg::plan_t       push_plan,
	input  wire logic                  pop,
	output wsmc_pkg::plan_t            head_plan,
	output wsmc_pkg::queue_stat_t      q_stat
);

	localparam int DEPTH = wsmc_pkg::QUEUE_DEPTH;
	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	wsmc_pkg::plan_t       mem_q [DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0]   count_q;

	assign q_stat.full = (count_q == CNT_BITS'(DEPTH));
	assign q_stat.not_empty = (count_q != '0);
	assign head_plan = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_plan;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/wsmc_back.sv =====
// Back part: takes plans from the queue and sends their messages, one per
// cycle while msg_ready allows, through the output register. Uses wsmc_pkg.
`default_nettype none
module wsmc_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire wsmc_pkg::plan_t       head_plan,
	input  wire wsmc_pkg::queue_stat_t q_stat,
	output logic                       pop,
	output logic                       msg_valid,
	input  wire logic                  msg_ready,
	output logic [3:0]                 message_kind,
	output logic [7:0]                 mode_out,
	output logic signed [15:0]         horizontal_out,
	output logic signed [15:0]         vertical_out,
	output logic [9:0]                 status_flags,
	output logic [2:0]                 active_sequence,
	output logic                       last_of_run
);

	logic                 valid_q;
	logic                 phase_q;
	wsmc_pkg::msg_kind_t  kind_q;
	logic [7:0]           mode_q;
	logic [15:0]          horizontal_q, vertical_q;
	logic [9:0]           flags_q;
	logic [2:0]           seq_q;
	logic                 last_q;

	logic                 load;
	wsmc_pkg::msg_kind_t  kind_sel;
	logic                 last_sel;
	logic                 trk_sel;
	logic                 status_sel;

	assign load = (!valid_q || msg_ready) && q_stat.not_empty;
	assign kind_sel = phase_q ? head_plan.kind_b : head_plan.kind_a;
	assign last_sel = phase_q || !head_plan.two;
	assign pop = load && last_sel;
	assign trk_sel = (kind_sel == wsmc_pkg::MSG_TRACK_START)
		|| (kind_sel == wsmc_pkg::MSG_TRACK_UPDATE);
	assign status_sel = (kind_sel == wsmc_pkg::MSG_STATUS);

	// Control: output valid and which half of a pair is next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				phase_q <= !last_sel;
			end else if (msg_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= kind_sel;
			mode_q <= trk_sel ? head_plan.mode : '0;
			horizontal_q <= trk_sel ? head_plan.horizontal : '0;
			vertical_q <= trk_sel ? head_plan.vertical : '0;
			flags_q <= status_sel ? head_plan.flags : '0;
			seq_q <= status_sel ? head_plan.sequence_code : '0;
			last_q <= last_sel;
		end
	end

	assign msg_valid = valid_q;
	assign message_kind = kind_q;
	assign mode_out = mode_q;
	assign horizontal_out = horizontal_q;
	assign vertical_out = vertical_q;
	assign status_flags = flags_q;
	assign active_sequence = seq_q;
	assign last_of_run = last_q;

	// Second half of a pair is pending only while its plan is still queued
	a_phase_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> q_stat.not_empty)
		else $error("second message pending with empty queue");

	// Entering the second half follows a first message that is not the last
	a_pair_first_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(phase_q) |-> (valid_q && !last_q))
		else $error("first of a pair marked last");

	// Releasing a plan shows its final message next cycle
	a_pop_shows_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (valid_q && last_q))
		else $error("plan released without its final message");

	// A status report is always a run of one
	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && kind_q == wsmc_pkg::MSG_STATUS) |-> last_q)
		else $error("status report not marked last");

endmodule
`default_nettype wire
